### rtl/slot_allocator_with_wait_fifo_top_defines.svh
// Shared assertion macros for the slot allocator.
// Each macro expects clk and arst_n in scope.
`ifndef SLOT_ALLOCATOR_WITH_WAIT_FIFO_TOP_DEFINES_SVH
`define SLOT_ALLOCATOR_WITH_WAIT_FIFO_TOP_DEFINES_SVH

// Same-cycle implication.
`define SAWF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SAWF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/sawf_pkg.sv
package sawf_pkg;

	localparam int NUM_SLOTS   = 4;
	localparam int QUEUE_DEPTH = 16;
	localparam int ID_WIDTH    = 16;

	// Field widths fixed by the port definition.
	localparam int SLOT_W = 2;
	localparam int CNT_W  = 5;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic MODE_REQUEST = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	typedef enum logic [2:0] {
		ST_GRANTED    = 3'd0,
		ST_QUEUED     = 3'd1,
		ST_DROPPED    = 3'd2,
		ST_FREED      = 3'd3,
		ST_REASSIGNED = 3'd4,
		ST_BAD_INDEX  = 3'd5
	} status_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic capture;
		logic execute;
	} ctrl_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic out_stall;
	} dp_sts_t;

endpackage

### rtl/sawf_req_if.sv
interface sawf_req_if;
	import sawf_pkg::*;

	logic                valid;
	logic                ready;
	logic                mode;
	logic [ID_WIDTH-1:0] requester_id;
	logic [SLOT_W-1:0]   slot_index;

	modport source(output valid, mode, requester_id, slot_index, input ready);
	modport sink(input valid, mode, requester_id, slot_index, output ready);
endinterface

### rtl/sawf_rsp_if.sv
interface sawf_rsp_if;
	import sawf_pkg::*;

	logic                valid;
	logic                ready;
	status_t             status;
	logic [SLOT_W-1:0]   granted_slot;
	logic [ID_WIDTH-1:0] granted_id;
	logic [CNT_W-1:0]    waiting_count;

	modport source(output valid, status, granted_slot, granted_id, waiting_count,
		input ready);
	modport sink(input valid, status, granted_slot, granted_id, waiting_count,
		output ready);
endinterface

### rtl/sawf_ctrl.sv
module sawf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sawf_pkg::dp_sts_t   sts,
	output sawf_pkg::ctrl_cmd_t cmd
);
	import sawf_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		in_ready    = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				// hold while the result register is still occupied
				if (!sts.out_stall) begin
					cmd.execute = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/sawf_dp.sv
`include "slot_allocator_with_wait_fifo_top_defines.svh"

module sawf_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sawf_pkg::ctrl_cmd_t                   cmd,
	output sawf_pkg::dp_sts_t                     sts,
	input  logic                                  mode,
	input  logic [sawf_pkg::ID_WIDTH-1:0]         requester_id,
	input  logic [sawf_pkg::SLOT_W-1:0]           slot_index,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output sawf_pkg::status_t                     status,
	output logic [sawf_pkg::SLOT_W-1:0]           granted_slot,
	output logic [sawf_pkg::ID_WIDTH-1:0]         granted_id,
	output logic [sawf_pkg::CNT_W-1:0]            waiting_count
);
	import sawf_pkg::*;

	// captured item
	logic                mode_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [SLOT_W-1:0]   idx_q;

	// allocator state
	logic [NUM_SLOTS-1:0] busy_q, busy_d;
	logic [QPTR_W-1:0]    head_q, head_d, tail_q, tail_d;
	logic [CNT_W-1:0]     count_q, count_d;

	// wait store and its registered head read
	logic [ID_WIDTH-1:0] wait_mem [QUEUE_DEPTH];
	logic [ID_WIDTH-1:0] rd_q;
	logic                push;

	// result register
	logic                out_valid_q;
	status_t             status_q, status_d;
	logic [SLOT_W-1:0]   slot_q, slot_d;
	logic [ID_WIDTH-1:0] gid_q, gid_d;
	logic [CNT_W-1:0]    wcnt_q;

	logic              free_any;
	logic [SLOT_W-1:0] free_idx;
	logic              idx_ok;
	logic              q_full;
	logic              q_empty;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// lowest-numbered free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_any = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	assign idx_ok  = {1'b0, idx_q} < (SLOT_W + 1)'(NUM_SLOTS);
	assign q_full  = count_q == CNT_W'(QUEUE_DEPTH);
	assign q_empty = count_q == '0;

	always_comb begin
		busy_d   = busy_q;
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		push     = 1'b0;
		status_d = ST_GRANTED;
		slot_d   = '0;
		gid_d    = id_q;
		if (mode_q == MODE_REQUEST) begin
			if (free_any) begin
				busy_d[free_idx] = 1'b1;
				status_d         = ST_GRANTED;
				slot_d           = free_idx;
			end else if (q_full) begin
				status_d = ST_DROPPED;
			end else begin
				push     = 1'b1;
				tail_d   = ptr_inc(tail_q);
				count_d  = count_q + 1'b1;
				status_d = ST_QUEUED;
			end
		end else begin
			slot_d = idx_q;
			gid_d  = '0;
			if (!idx_ok) begin
				status_d = ST_BAD_INDEX;
			end else if (!q_empty) begin
				// move the oldest waiter straight into the released slot
				busy_d[idx_q] = 1'b1;
				head_d        = ptr_inc(head_q);
				count_d       = count_q - 1'b1;
				status_d      = ST_REASSIGNED;
				gid_d         = rd_q;
			end else begin
				busy_d[idx_q] = 1'b0;
				status_d      = ST_FREED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.execute) begin
				busy_q  <= busy_d;
				head_q  <= head_d;
				tail_q  <= tail_d;
				count_q <= count_d;
			end
			if (cmd.execute) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode;
			id_q   <= requester_id;
			idx_q  <= slot_index;
		end
		if (cmd.execute) begin
			status_q <= status_d;
			slot_q   <= slot_d;
			gid_q    <= gid_d;
			wcnt_q   <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute && push) begin
			wait_mem[tail_q] <= id_q;
		end
		rd_q <= wait_mem[head_q];
	end

	assign sts.out_stall = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign granted_slot  = slot_q;
	assign granted_id    = gid_q;
	assign waiting_count = wcnt_q;

	`SAWF_ASSERT_IMP(a_cnt_max, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "wait count overflow")
	`SAWF_ASSERT_IMP(a_ptr_meet, q_empty || q_full, head_q == tail_q, "queue pointers disagree")
	`SAWF_ASSERT_IMP(a_no_overwrite, cmd.execute, !sts.out_stall, "result overwritten")
	`SAWF_ASSERT_NXT(a_exec_valid, cmd.execute, out_valid_q, "result not presented")

endmodule

### rtl/slot_allocator_with_wait_fifo_top.sv
// Sequence: a word is captured on the accepting edge in IDLE; in EXEC, once the result
// register is free, execute loads the result register, and the result is offered from there.
// No new word is taken until the current one is executed; the registered read of the wait store
// at the queue head is why execute is a separate step after the accept.
// A new word is taken while the previous result still waits in the output register.
// Reset (arst_n low, asynchronous): all slots free, queue empty, no result pending.
module slot_allocator_with_wait_fifo_top (
	input logic      clk,
	input logic      arst_n,
	sawf_req_if.sink   req,
	sawf_rsp_if.source rsp
);
	import sawf_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// Controller: accept a word in IDLE, then execute it once the result register is free.
	sawf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: slot busy bits, wait queue memory and pointers, result register.
	sawf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.mode          (req.mode),
		.requester_id  (req.requester_id),
		.slot_index    (req.slot_index),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.status        (rsp.status),
		.granted_slot  (rsp.granted_slot),
		.granted_id    (rsp.granted_id),
		.waiting_count (rsp.waiting_count)
	);

endmodule

### test/tb.sv
module tb;
	import sawf_pkg::*;

	// Clock period is 12 time units. The whole run must end well inside the cycle limit.
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_WORDS = 400;
	localparam int IDLE_PCT     = 12;

	// One response word, as expected or as observed on the response channel.
	typedef struct {
		status_t             status;
		logic [SLOT_W-1:0]   slot;
		logic [ID_WIDTH-1:0] id;
		logic [CNT_W-1:0]    count;
	} outcome_t;

	// Shadow of the slot table and the wait queue. Every accepted request word
	// advances the shadow and leaves one expected outcome behind.
	class allocation_tracker;
		bit                  slot_taken[NUM_SLOTS];
		logic [ID_WIDTH-1:0] waitlist[QUEUE_DEPTH];
		int unsigned         head;
		int unsigned         tail;
		int unsigned         queued;
		outcome_t            awaited[$];
		int unsigned         mismatches;
		int unsigned         seen[6];

		function new();
			head = 0;
			tail = 0;
			queued = 0;
			mismatches = 0;
			foreach (slot_taken[i])
				slot_taken[i] = 1'b0;
			foreach (seen[i])
				seen[i] = 0;
		endfunction

		// Work out the outcome of one accepted request word.
		function void note_word(logic mode, logic [ID_WIDTH-1:0] id,
			logic [SLOT_W-1:0] idx);
			outcome_t o;
			bit       placed;
			placed = 1'b0;
			o.slot = '0;
			o.id = '0;
			if (mode == MODE_REQUEST) begin
				o.id = id;
				for (int i = 0; i < NUM_SLOTS; i++) begin
					if (!placed && !slot_taken[i]) begin
						slot_taken[i] = 1'b1;
						o.status = ST_GRANTED;
						o.slot = SLOT_W'(i);
						placed = 1'b1;
					end
				end
				if (!placed) begin
					if (queued >= QUEUE_DEPTH) begin
						o.status = ST_DROPPED;
					end else begin
						waitlist[tail] = id;
						tail = (tail + 1) % QUEUE_DEPTH;
						queued++;
						o.status = ST_QUEUED;
					end
				end
			end else begin
				o.slot = idx;
				if (int'(idx) >= NUM_SLOTS) begin
					o.status = ST_BAD_INDEX;
				end else if (queued > 0) begin
					// Hand the freed slot straight to the oldest waiter.
					o.id = waitlist[head];
					head = (head + 1) % QUEUE_DEPTH;
					queued--;
					slot_taken[idx] = 1'b1;
					o.status = ST_REASSIGNED;
				end else begin
					slot_taken[idx] = 1'b0;
					o.status = ST_FREED;
				end
			end
			o.count = CNT_W'(queued);
			seen[int'(o.status)]++;
			awaited.push_back(o);
		endfunction

		// Compare one response word with the oldest expected outcome.
		function void check_word(outcome_t got);
			outcome_t want;
			if (awaited.size() == 0) begin
				$error("response word with nothing expected: status %0d slot %0d id %h",
					got.status, got.slot, got.id);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
			if (got.slot !== want.slot) begin
				$error("granted_slot: expected %0d, got %0d", want.slot, got.slot);
				mismatches++;
			end
			if (got.id !== want.id) begin
				$error("granted_id: expected %h, got %h", want.id, got.id);
				mismatches++;
			end
			if (got.count !== want.count) begin
				$error("waiting_count: expected %0d, got %0d", want.count, got.count);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	int   cycle_count;

	allocation_tracker tracker;

	sawf_req_if req_if();
	sawf_rsp_if rsp_if();

	slot_allocator_with_wait_fifo_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if.sink),
		.rsp(rsp_if.source)
	);

	always #6 clk = ~clk;

	// Abort the run if it hangs; a correct run ends far below this.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Response side: drop ready at random, except during the calm stretch.
	always @(negedge clk) begin
		if (arst_n)
			rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// Sample both channels at the rising edge, before the block updates.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_if.valid && req_if.ready)
				tracker.note_word(req_if.mode, req_if.requester_id, req_if.slot_index);
			if (rsp_if.valid && rsp_if.ready)
				tracker.check_word('{rsp_if.status, rsp_if.granted_slot,
					rsp_if.granted_id, rsp_if.waiting_count});
		end
	end

	// Mostly random ids, with the all-zero and all-one extremes mixed in.
	function automatic logic [ID_WIDTH-1:0] pick_id();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return ID_WIDTH'($urandom());
		endcase
	endfunction

	// Offer one word, starting at a falling edge; hold it until it is taken.
	task automatic send_word(input logic mode, input logic [ID_WIDTH-1:0] id,
		input logic [SLOT_W-1:0] idx);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			// Idle cycle: lower valid and scramble the payload as noise.
			req_if.valid        <= 1'b0;
			req_if.mode         <= 1'($urandom());
			req_if.requester_id <= ID_WIDTH'($urandom());
			req_if.slot_index   <= SLOT_W'($urandom());
			@(negedge clk);
		end
		req_if.valid        <= 1'b1;
		req_if.mode         <= mode;
		req_if.requester_id <= id;
		req_if.slot_index   <= idx;
		do
			@(posedge clk);
		while (!req_if.ready);
		@(negedge clk);
	endtask

	initial begin
		int unsigned bias;
		logic        mode;
		tracker = new();
		clk = 1'b0;
		arst_n = 1'b0;
		calm = 1'b0;
		cycle_count = 0;
		req_if.valid = 1'b0;
		req_if.mode = MODE_REQUEST;
		req_if.requester_id = '0;
		req_if.slot_index = '0;
		rsp_if.ready = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Release a slot that is already free while the queue is empty.
		send_word(MODE_RELEASE, '0, 2'd0);
		// Fill every slot, with the id extremes and both checkerboards.
		send_word(MODE_REQUEST, 16'h0000, 2'd0);
		send_word(MODE_REQUEST, 16'hFFFF, 2'd0);
		send_word(MODE_REQUEST, 16'h5555, 2'd0);
		send_word(MODE_REQUEST, 16'hAAAA, 2'd0);
		// Fill the wait queue with walking-one ids, then overflow it.
		for (int k = 0; k < QUEUE_DEPTH; k++)
			send_word(MODE_REQUEST, ID_WIDTH'(1) << k, 2'd3);
		send_word(MODE_REQUEST, 16'hFFFF, 2'd1);
		// Freed slots go straight to the oldest waiters.
		send_word(MODE_RELEASE, 16'hFFFF, 2'd3);
		send_word(MODE_RELEASE, '0, 2'd1);

		// Random part: alternate request-heavy and release-heavy phases so the
		// queue fills to the drop point, drains to empty and wraps around.
		for (int p = 0; p < 8; p++) begin
			bias = (p % 2 == 0) ? 75 : 30;
			calm = (p == 3 || p == 4);
			for (int n = 0; n < RANDOM_WORDS / 8; n++) begin
				mode = ($urandom_range(99) < bias) ? MODE_REQUEST : MODE_RELEASE;
				send_word(mode, pick_id(), SLOT_W'($urandom_range(NUM_SLOTS - 1)));
			end
		end
		calm = 1'b0;
		req_if.valid <= 1'b0;

		// Drain outstanding responses, then allow for the pipeline latency.
		while (tracker.awaited.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		if (tracker.awaited.size() != 0) begin
			$error("%0d expected response words never arrived", tracker.awaited.size());
			tracker.mismatches++;
		end

		$display("Run covered %0d granted, %0d queued, %0d dropped, %0d freed, %0d reassigned",
			tracker.seen[ST_GRANTED], tracker.seen[ST_QUEUED], tracker.seen[ST_DROPPED],
			tracker.seen[ST_FREED], tracker.seen[ST_REASSIGNED]);
		$display("with random idle cycles on both channels and one calm stretch");
		if (tracker.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
